// File: rtl/cds_pkg.sv
package cds_pkg;

  // Width of the millisecond time base
  localparam int unsigned TimeW = 32;

  // Command codes carried in the operation field
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgOvrEnable = 2'd0,
    CfgOvrType   = 2'd1,
    CfgTimeout   = 2'd2,
    CfgRetryLim  = 2'd3
  } cfg_idx_e;

  // Error event codes
  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvTimeout = 2'd1;
  localparam logic [1:0] EvRange   = 2'd2;
  localparam logic [1:0] EvCal     = 2'd3;

  // Material codes
  localparam logic [2:0] MatUnknown = 3'd0;
  localparam logic [2:0] MatPlastic = 3'd1;
  localparam logic [2:0] MatPaper   = 3'd2;
  localparam logic [2:0] MatInvalid = 3'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] TimeoutRst  = 16'd2000;
  localparam logic [2:0]  RetryLimRst = 3'd3;

  // Acceptance window for the latched readings
  localparam logic [15:0] WeightMin = 16'd10;
  localparam logic [15:0] WeightMax = 16'd500;
  localparam logic [7:0]  HeightMin = 8'd50;
  localparam logic [7:0]  HeightMax = 8'd200;
  localparam logic [7:0]  DiamMin   = 8'd50;
  localparam logic [7:0]  DiamMax   = 8'd120;

  // Classification thresholds
  localparam logic [6:0] PlasticTranspMin = 7'd70;
  localparam logic [6:0] PlasticMoistMax  = 7'd20;
  localparam logic [6:0] PaperTranspMax   = 7'd30;
  localparam logic [6:0] PaperMoistMin    = 7'd40;

  // One input item
  typedef struct packed {
    logic             operation;
    logic [TimeW-1:0] now_ms;
    logic             cup_present;
    logic             calibration_ok;
    logic             measurements_done;
    logic [12:0]      weight_reading;
    logic [7:0]       height_mm;
    logic [7:0]       diameter_mm;
    logic [6:0]       transparency_pct;
    logic [6:0]       moisture_pct;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  phase;
    logic        detect_status;
    logic        start_refused;
    logic [1:0]  error_event;
    logic [2:0]  material;
    logic [15:0] weight_tenths;
    logic [7:0]  height_out;
    logic [7:0]  diameter_out;
    logic [6:0]  transparency_out;
    logic [6:0]  moisture_out;
  } res_item_t;

  // Latched measurement set
  typedef struct packed {
    logic [15:0] weight;
    logic [7:0]  height;
    logic [7:0]  diameter;
    logic [6:0]  transparency;
    logic [6:0]  moisture;
  } meas_t;

  // Verdict of the analysis logic
  typedef struct packed {
    logic       in_range;
    logic [2:0] material;
  } verdict_t;

endpackage

// File: rtl/cds_analyze.sv
module cds_analyze (
  input  cds_pkg::meas_t    meas_i,
  input  logic              ovr_enable_i,
  input  logic [2:0]        ovr_type_i,
  output cds_pkg::verdict_t verdict_o
);

  logic weight_ok;
  logic height_ok;
  logic diam_ok;
  logic [2:0] class_mat;

  // Range window on the three dimensions
  assign weight_ok = (meas_i.weight >= cds_pkg::WeightMin) &&
                     (meas_i.weight <= cds_pkg::WeightMax);
  assign height_ok = (meas_i.height >= cds_pkg::HeightMin) &&
                     (meas_i.height <= cds_pkg::HeightMax);
  assign diam_ok   = (meas_i.diameter >= cds_pkg::DiamMin) &&
                     (meas_i.diameter <= cds_pkg::DiamMax);

  // Material from transparency and moisture; plastic is checked first
  always_comb begin
    if ((meas_i.transparency > cds_pkg::PlasticTranspMin) &&
        (meas_i.moisture < cds_pkg::PlasticMoistMax)) begin
      class_mat = cds_pkg::MatPlastic;
    end else if ((meas_i.transparency < cds_pkg::PaperTranspMax) &&
                 (meas_i.moisture > cds_pkg::PaperMoistMin)) begin
      class_mat = cds_pkg::MatPaper;
    end else begin
      class_mat = cds_pkg::MatInvalid;
    end
  end

  assign verdict_o.in_range = weight_ok && height_ok && diam_ok;
  assign verdict_o.material = ovr_enable_i ? ovr_type_i : class_mat;

endmodule

// File: rtl/cup_detection_sequencer.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_stall_o   | in_data_i  (cds_pkg::in_item_t)
// out      | output    | out_valid_o / out_stall_i | out_data_o (cds_pkg::res_item_t)
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The phase update is a single pass of compares and a small adder from the
// input port into the sequencer state and the output buffer, so one item is
// taken per clock while in_stall_o is low.
// Every item gives exactly one result, registered in the output buffer.
// A two-entry output buffer (result register plus skid) keeps the input open
// while a result waits; in_stall_o rises only when both entries are full.
// Reset is asynchronous, active low, and leaves calibration pending.
module cup_detection_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cds_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cds_pkg::res_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  cds_pkg::cfg_idx_e  cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhCheck   = 3'd1,
    PhMeasure = 3'd2,
    PhAnalyze = 3'd3,
    PhDone    = 3'd4,
    PhError   = 3'd5
  } phase_e;

  // Configuration registers
  logic        ovr_en_q;
  logic [2:0]  ovr_type_q;
  logic [15:0] timeout_q;
  logic [2:0]  retry_lim_q;

  // Sequencer state
  phase_e                    phase_q, phase_d;
  logic                      status_q, status_d;
  logic                      cal_pend_q, cal_pend_d;
  logic [cds_pkg::TimeW-1:0] start_q, start_d;
  logic [2:0]                retry_q, retry_d;
  cds_pkg::meas_t            meas_q, meas_d;
  logic [2:0]                mat_q, mat_d;

  // Output buffer
  logic               out_vld_q, out_vld_d;
  logic               skid_vld_q, skid_vld_d;
  cds_pkg::res_item_t out_q, out_d;
  cds_pkg::res_item_t skid_q, skid_d;

  logic                      in_acc;
  logic                      out_fire;
  logic                      refused;
  logic [1:0]                event_code;
  logic [cds_pkg::TimeW-1:0] elapsed;
  logic [16:0]               weight_x10;
  logic [15:0]               weight_sat;
  cds_pkg::verdict_t         verdict;
  cds_pkg::res_item_t        res;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_fire    = out_vld_q && !out_stall_i;
  assign in_stall_o  = skid_vld_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Range check and classification on the latched readings
  cds_analyze u_analyze (
    .meas_i       (meas_q),
    .ovr_enable_i (ovr_en_q),
    .ovr_type_i   (ovr_type_q),
    .verdict_o    (verdict)
  );

  // Elapsed time wraps with the time base
  assign elapsed = in_data_i.now_ms - start_q;

  // Weight times ten as 8w + 2w, saturated to 16 bits
  assign weight_x10 = {in_data_i.weight_reading, 3'b000} +
                      {3'b000, in_data_i.weight_reading, 1'b0};
  assign weight_sat = weight_x10[16] ? 16'hFFFF : weight_x10[15:0];

  // Next state for the item on the input port
  always_comb begin
    phase_d    = phase_q;
    status_d   = status_q;
    cal_pend_d = cal_pend_q;
    start_d    = start_q;
    retry_d    = retry_q;
    meas_d     = meas_q;
    mat_d      = mat_q;
    refused    = 1'b0;
    event_code = cds_pkg::EvNone;
    if (in_data_i.operation == cds_pkg::OpStart) begin
      if (phase_q == PhIdle || phase_q == PhDone || phase_q == PhError) begin
        phase_d  = PhCheck;
        status_d = 1'b0;
        retry_d  = '0;
        meas_d   = '0;
        mat_d    = cds_pkg::MatUnknown;
      end else begin
        refused = 1'b1;
      end
    end else if (cal_pend_q) begin
      if (in_data_i.calibration_ok) begin
        cal_pend_d = 1'b0;
      end else begin
        event_code = cds_pkg::EvCal;
      end
    end else begin
      unique case (phase_q)
        PhCheck: begin
          if (in_data_i.cup_present) begin
            phase_d = PhMeasure;
            start_d = in_data_i.now_ms;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhMeasure: begin
          if (elapsed > cds_pkg::TimeW'(timeout_q)) begin
            status_d   = 1'b1;
            phase_d    = PhError;
            event_code = cds_pkg::EvTimeout;
          end else begin
            meas_d.weight       = weight_sat;
            meas_d.height       = in_data_i.height_mm;
            meas_d.diameter     = in_data_i.diameter_mm;
            meas_d.transparency = in_data_i.transparency_pct;
            meas_d.moisture     = in_data_i.moisture_pct;
            if (in_data_i.measurements_done) begin
              phase_d = PhAnalyze;
            end
          end
        end
        PhAnalyze: begin
          if (!verdict.in_range) begin
            if (retry_q < retry_lim_q) begin
              retry_d = retry_q + 3'd1;
              phase_d = PhMeasure;
            end else begin
              status_d   = 1'b1;
              phase_d    = PhError;
              event_code = cds_pkg::EvRange;
            end
          end else begin
            mat_d   = verdict.material;
            phase_d = PhDone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result built from the state after the step
  always_comb begin
    res.phase            = phase_d;
    res.detect_status    = status_d;
    res.start_refused    = refused;
    res.error_event      = event_code;
    res.material         = mat_d;
    res.weight_tenths    = meas_d.weight;
    res.height_out       = meas_d.height;
    res.diameter_out     = meas_d.diameter;
    res.transparency_out = meas_d.transparency;
    res.moisture_out     = meas_d.moisture;
  end

  // Output buffer: the skid entry drains into the result register first
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (out_fire) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = in_acc;
        skid_d     = res;
      end else begin
        out_vld_d = in_acc;
        out_d     = res;
      end
    end else if (out_vld_q) begin
      if (in_acc) begin
        skid_vld_d = 1'b1;
        skid_d     = res;
      end
    end else if (in_acc) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  // State, configuration and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_en_q    <= 1'b0;
      ovr_type_q  <= '0;
      timeout_q   <= cds_pkg::TimeoutRst;
      retry_lim_q <= cds_pkg::RetryLimRst;
      phase_q     <= PhIdle;
      status_q    <= 1'b0;
      cal_pend_q  <= 1'b1;
      start_q     <= '0;
      retry_q     <= '0;
      meas_q      <= '0;
      mat_q       <= cds_pkg::MatUnknown;
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
      out_q       <= '0;
      skid_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          cds_pkg::CfgOvrEnable: ovr_en_q    <= cfg_data_i[0];
          cds_pkg::CfgOvrType:   ovr_type_q  <= cfg_data_i[2:0];
          cds_pkg::CfgTimeout:   timeout_q   <= cfg_data_i;
          cds_pkg::CfgRetryLim:  retry_lim_q <= cfg_data_i[2:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        phase_q    <= phase_d;
        status_q   <= status_d;
        cal_pend_q <= cal_pend_d;
        start_q    <= start_d;
        retry_q    <= retry_d;
        meas_q     <= meas_d;
        mat_q      <= mat_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
      out_q      <= out_d;
      skid_q     <= skid_d;
    end
  end

`ifndef ASSERT_OFF
  // The skid entry is only ever used behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty result register");

  // An accepted start from a resting phase always lands in checking
  a_start_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.operation == cds_pkg::OpStart) &&
    (phase_q == PhIdle || phase_q == PhDone || phase_q == PhError)
    |=> phase_q == PhCheck)
    else $error("start did not move the sequencer to checking");

  // Calibration is only cleared by an accepted item
  a_cal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cal_pend_q) |-> $past(in_acc))
    else $error("calibration cleared without a transfer");

  // A refused start leaves the phase untouched
  a_refuse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && refused |=> phase_q == $past(phase_q))
    else $error("refused start changed the phase");
`endif

endmodule
